>>> rtl/crq_pkg.sv
// Shared types and codes for the circular queue with search.
package crq_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    localparam int CAP_BITS  = 5;
    localparam int CAP_RESET = 16;

    // per-cycle command broadcast along the cell chain
    typedef struct packed {
        logic enq;   // load first free cell with the word
        logic deq;   // every cell takes its upper neighbor's contents
        logic clr;   // drop all entries
    } crq_ctrl_t;

endpackage

>>> rtl/crq_cell.sv
// One queue slot: holds a word and its valid bit, shifts toward the head on dequeue.
module crq_cell
    import crq_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  crq_ctrl_t            ctrl,
    input  logic [WORD_BITS-1:0] word,
    input  logic                 prev_valid,   // cell toward the head
    input  logic                 next_valid,   // cell toward the tail
    input  logic [WORD_BITS-1:0] next_data,
    output logic                 valid,
    output logic [WORD_BITS-1:0] data,
    output logic                 match
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 take_word;

    // the first empty cell behind a filled one is the tail slot
    assign take_word = ctrl.enq && !valid_reg && prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.deq)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (take_word)
        begin
            valid_next = 1'b1;
            data_next  = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign match = valid_reg && (data_reg == word);

endmodule

>>> rtl/circular_queue_with_search.sv
// Top level of the FIFO queue with parallel search, built as a chain of cells.
//
// Input stream (s_axis_*): tuser carries the operation (enqueue, dequeue,
// search, or no-op), tdata the word to enqueue or search for. One item in
// gives exactly one result item out (m_axis_*): tdata carries the dequeued
// word, the search hit, the occupancy and the empty and full flags; tuser
// carries the status (ok, overflow, underflow).
// The result is registered at the edge that accepts the item. An item can
// be taken every cycle while the receiver takes each result; the cell chain
// updates at that edge, and the search is a compare in every cell ORed together.
// When the receiver stalls, the result register holds and s_axis_tready
// drops until the result is taken, so one item is in flight at most.
// Writing cfg_wdata with cfg_we sets the capacity in use (0 acts as 1,
// above DEPTH acts as DEPTH) and empties the queue; write only while idle.
// Reset empties the queue, sets capacity to 16 and clears the output valid.
// Held words are stored in their low WORD_BITS bits; dequeued words are
// sign-extended to 32 bits.
module circular_queue_with_search
    import crq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int OUT_BITS = 32 + 1 + CNT_W + 2,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CAP_BITS-1:0] cfg_wdata,      // capacity
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // value[31:0]
    input  logic [1:0]          s_axis_tuser,   // operation[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // data_out[31:0], found, occupancy,
                                                // is_empty, is_full, zero fill
    output logic [1:0]          m_axis_tuser    // status[1:0]
);

    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    logic [CAP_BITS-1:0]  cap_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CMP_W-1:0]     cap_eff;
    logic [CMP_W-1:0]     count_cmp;
    logic [CMP_W-1:0]     count_next_cmp;

    logic                 out_valid_reg;
    logic [31:0]          data_out_reg;
    logic [31:0]          data_out_next;
    status_t              status_reg;
    status_t              status_next;
    logic                 found_reg;
    logic                 found_next;
    logic [CNT_W-1:0]     occ_reg;
    logic                 empty_reg;
    logic                 full_reg;

    logic                 accept;
    op_t                  op;
    crq_ctrl_t            ctrl;
    logic [WORD_BITS-1:0] word;
    logic [31:0]          head_ext;
    logic                 is_full_now;
    logic                 is_empty_now;

    logic [WORD_BITS-1:0] data_w  [DEPTH];
    logic                 valid_w [DEPTH];
    logic [DEPTH-1:0]     match_w;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tuser);

    // word width conversion on the way in and out
    if (WORD_BITS <= 32)
    begin : g_word_in_narrow
        assign word = s_axis_tdata[WORD_BITS-1:0];
    end
    else
    begin : g_word_in_wide
        assign word = {{(WORD_BITS-32){1'b0}}, s_axis_tdata};
    end

    if (WORD_BITS < 32)
    begin : g_word_out_narrow
        assign head_ext = {{(32-WORD_BITS){data_w[0][WORD_BITS-1]}}, data_w[0]};
    end
    else
    begin : g_word_out_wide
        assign head_ext = data_w[0][31:0];
    end

    // capacity actually in force
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(DEPTH))
        begin
            cap_eff = CMP_W'(DEPTH);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign count_cmp    = CMP_W'(count_reg);
    assign is_full_now  = (count_cmp == cap_eff);
    assign is_empty_now = (count_reg == '0);

    // command for the chain and the result of this item
    always_comb
    begin
        ctrl          = '0;
        ctrl.clr      = cfg_we;
        count_next    = count_reg;
        data_out_next = '0;
        status_next   = ST_OK;
        found_next    = 1'b0;
        unique case (op)
            OP_ENQ:
            begin
                if (is_full_now)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ctrl.enq   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DEQ:
            begin
                if (is_empty_now)
                begin
                    data_out_next = '1;
                    status_next   = ST_UNDERFLOW;
                end
                else
                begin
                    ctrl.deq      = accept;
                    data_out_next = head_ext;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            OP_SEARCH:
            begin
                found_next = |match_w;
            end
            OP_NOP:
            begin
                found_next = 1'b0;
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    assign count_next_cmp = CMP_W'(count_next);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 prev_v;
        logic                 next_v;
        logic [WORD_BITS-1:0] next_d;

        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_v = valid_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_v = 1'b0;
            assign next_d = '0;
        end
        else
        begin : g_inner
            assign next_v = valid_w[i+1];
            assign next_d = data_w[i+1];
        end

        crq_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .word       (word),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_data  (next_d),
            .valid      (valid_w[i]),
            .data       (data_w[i]),
            .match      (match_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_BITS'(CAP_RESET);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg   <= cfg_wdata;
                count_reg <= '0;
            end
            else if (accept)
            begin
                count_reg <= count_next;
            end

            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg <= data_out_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
            occ_reg      <= count_next;
            empty_reg    <= (count_next == '0);
            full_reg     <= (count_next_cmp == cap_eff);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({full_reg, empty_reg, occ_reg, found_reg, data_out_reg});
    assign m_axis_tuser  = status_reg;

endmodule
